FILE: design/md5he_pkg.sv
// Shared types, constants and round tables of the MD5 hash engine.
`default_nettype none
package md5he_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned WADDR_W   = $clog2(BLK_WORDS);

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [3:0][31:0] IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [2:0] {
    WR_BYTE,
    WR_PAD,
    WR_ZERO,
    WR_LEN_LO,
    WR_LEN_HI
  } wr_sel_e;

  typedef struct packed {
    logic               take_byte;
    logic               wr_en;
    wr_sel_e            wr_sel;
    logic [WADDR_W-1:0] wr_addr;
    logic               load;
    logic               round_en;
    logic               add;
    logic               clr_msg;
    logic [1:0]         out_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } sts_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [WADDR_W-1:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    case (r[5:4])
      2'd0:    i = r[3:0];
      2'd1:    i = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    i = 4'(r[3:0] * 4'd3 + 4'd5);
      2'd3:    i = 4'(r[3:0] * 4'd7);
      default: i = 4'd0;
    endcase
    return i;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: design/md5he_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module md5he_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/md5he_datapath.sv
// Datapath of the MD5 hash engine: block store, length, chaining words and round unit.
`default_nettype none
module md5he_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire md5he_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    data_byte_i,
  output      md5he_pkg::sts_t sts_o,
  output      logic [31:0]   digest_word_o
);

  logic [5:0]        fill_q, fill_d;
  logic [63:0]       len_q, len_d;
  logic [31:0]       word_q, word_d;
  logic [3:0][31:0]  chain_q, chain_d;
  logic [31:0]       a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [5:0]        round_q, round_d;

  logic [31:0] word_ins;
  logic [31:0] pad_word;
  logic [31:0] wdata;
  logic [md5he_pkg::WADDR_W-1:0] raddr;
  logic [31:0] rdata;
  logic [31:0] f_val;
  logic [31:0] sum;

  always_comb begin
    word_ins = word_q;
    word_ins[{fill_q[1:0], 3'b000} +: 8] = data_byte_i;
  end

  assign pad_word = word_q | (32'(md5he_pkg::PAD_MARK) << {fill_q[1:0], 3'b000});

  always_comb begin
    case (cmd_i.wr_sel)
      md5he_pkg::WR_BYTE:   wdata = word_ins;
      md5he_pkg::WR_PAD:    wdata = pad_word;
      md5he_pkg::WR_ZERO:   wdata = '0;
      md5he_pkg::WR_LEN_LO: wdata = len_q[31:0];
      md5he_pkg::WR_LEN_HI: wdata = len_q[63:32];
      default:              wdata = '0;
    endcase
  end

  assign raddr = cmd_i.load ? md5he_pkg::msg_index(6'd0)
                            : md5he_pkg::msg_index(round_q + 6'd1);

  md5he_ram #(
    .WIDTH (md5he_pkg::WORD_W),
    .DEPTH (md5he_pkg::BLK_WORDS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (round_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      2'd3:    f_val = c_q ^ (b_q | ~d_q);
      default: f_val = '0;
    endcase
  end

  assign sum = f_val + a_q + md5he_pkg::round_const(round_q) + rdata;

  always_comb begin
    fill_d  = fill_q;
    len_d   = len_q;
    word_d  = word_q;
    chain_d = chain_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    round_d = round_q;
    if (cmd_i.take_byte) begin
      fill_d = fill_q + 6'd1;
      len_d  = len_q + 64'd8;
      word_d = (fill_q[1:0] == 2'd3) ? '0 : word_ins;
    end
    if (cmd_i.load) begin
      a_d     = chain_q[0];
      b_d     = chain_q[1];
      c_d     = chain_q[2];
      d_d     = chain_q[3];
      round_d = '0;
    end
    if (cmd_i.round_en) begin
      a_d     = d_q;
      b_d     = b_q + md5he_pkg::rotl32(sum, md5he_pkg::rot_amount(round_q));
      c_d     = b_q;
      d_d     = c_q;
      round_d = round_q + 6'd1;
    end
    if (cmd_i.add) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
    end
    if (cmd_i.clr_msg) begin
      fill_d  = '0;
      len_d   = '0;
      word_d  = '0;
      chain_d = md5he_pkg::IV_WORDS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      len_q   <= '0;
      word_q  <= '0;
      chain_q <= md5he_pkg::IV_WORDS;
      round_q <= '0;
    end else begin
      fill_q  <= fill_d;
      len_q   <= len_d;
      word_q  <= word_d;
      chain_q <= chain_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.round_last = (round_q == 6'd63);

  assign digest_word_o = md5he_pkg::bswap32(chain_q[cmd_i.out_sel]);

endmodule
`default_nettype wire

FILE: design/md5he_ctrl.sv
// Controller of the MD5 hash engine: byte intake, padding, round sequencing, digest beats.
`default_nettype none
module md5he_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            byte_valid_i,
  input  wire logic            last_i,
  output      logic            in_stall_o,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      logic [1:0]      word_index_o,
  output      logic            last_word_o,
  input  wire md5he_pkg::sts_t sts_i,
  output      md5he_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] widx_q, widx_d;
  logic       first_q, first_d;
  logic       final_q, final_d;
  logic       pend_q, pend_d;
  logic       padding_q, padding_d;
  logic [1:0] ocnt_q, ocnt_d;

  always_comb begin
    state_d   = state_q;
    widx_d    = widx_q;
    first_d   = first_q;
    final_d   = final_q;
    pend_d    = pend_q;
    padding_d = padding_q;
    ocnt_d    = ocnt_q;

    cmd_o           = '0;
    cmd_o.wr_sel    = md5he_pkg::WR_ZERO;
    cmd_o.wr_addr   = widx_q;
    cmd_o.out_sel   = ocnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd_o.take_byte = 1'b1;
            cmd_o.wr_sel    = md5he_pkg::WR_BYTE;
            cmd_o.wr_addr   = sts_i.fill[5:2];
            cmd_o.wr_en     = (sts_i.fill[1:0] == 2'd3);
          end
          if (byte_valid_i && (sts_i.fill == 6'd63)) begin
            state_d = S_LOAD;
            pend_d  = last_i;
          end else if (last_i) begin
            state_d   = S_PAD;
            first_d   = 1'b1;
            padding_d = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd_o.wr_en = 1'b1;
        if (first_q) begin
          cmd_o.wr_addr = sts_i.fill[5:2];
          cmd_o.wr_sel  = md5he_pkg::WR_PAD;
          final_d       = (sts_i.fill[5:3] != 3'b111);
          first_d       = 1'b0;
          widx_d        = sts_i.fill[5:2] + 4'd1;
          if (sts_i.fill[5:2] == 4'd15) begin
            state_d = S_LOAD;
          end
        end else begin
          if (final_q && (widx_q == 4'd14)) begin
            cmd_o.wr_sel = md5he_pkg::WR_LEN_LO;
          end else if (final_q && (widx_q == 4'd15)) begin
            cmd_o.wr_sel = md5he_pkg::WR_LEN_HI;
          end
          widx_d = widx_q + 4'd1;
          if (widx_q == 4'd15) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_RND;
      end
      S_RND: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        if (pend_q) begin
          pend_d    = 1'b0;
          state_d   = S_PAD;
          first_d   = 1'b1;
          padding_d = 1'b1;
        end else if (padding_q && !final_q) begin
          state_d = S_PAD;
          first_d = 1'b0;
          widx_d  = '0;
          final_d = 1'b1;
        end else if (padding_q) begin
          state_d = S_OUT;
          ocnt_d  = '0;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          ocnt_d = ocnt_q + 2'd1;
          if (ocnt_q == 2'd3) begin
            cmd_o.clr_msg = 1'b1;
            padding_d     = 1'b0;
            final_d       = 1'b0;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      widx_q    <= '0;
      first_q   <= 1'b0;
      final_q   <= 1'b0;
      pend_q    <= 1'b0;
      padding_q <= 1'b0;
      ocnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      widx_q    <= widx_d;
      first_q   <= first_d;
      final_q   <= final_d;
      pend_q    <= pend_d;
      padding_q <= padding_d;
      ocnt_q    <= ocnt_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = ocnt_q;
  assign last_word_o  = (ocnt_q == 2'd3);

endmodule
`default_nettype wire

FILE: design/md5_hash_engine_core.sv
// Top level of the MD5 hash engine: controller plus datapath.
// A plain message byte is taken without stalling the input. A byte that fills a
// 64-byte block stalls the input through a load step, 64 rounds through the
// single round unit (one round per cycle, the block RAM read one round ahead)
// and a step to add into the chaining words. A beat marked last then writes the
// 16 - fill/4 padding words into the block RAM, compresses, repeats both for an
// extra block when fewer than nine bytes of room remain, and emits the digest as
// four beats, A to D, one per cycle while the output is not stalled. The input
// is stalled from the last beat until the fourth digest beat is taken; then the
// controller, fill, length and chaining words return to their reset values.
`default_nettype none
module md5_hash_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        last_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] digest_word_o,
  output      logic [1:0]  word_index_o,
  output      logic        last_word_o
);

  md5he_pkg::cmd_t cmd;
  md5he_pkg::sts_t sts;

  md5he_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  md5he_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

endmodule
`default_nettype wire

FILE: design/md5he_checker.sv
// Port-level assertions for the MD5 hash engine and their bind to the top level.
`default_nettype none
module md5he_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        last_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [1:0]  word_index_o,
  input wire logic        last_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
                                   && $stable(word_index_o))
    else $error("stalled digest beat changed");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 2'd3)))
    else $error("last_word does not match word_index");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o
      |=> out_valid_o && (word_index_o == $past(word_index_o) + 2'd1))
    else $error("digest beats not consecutive");

  a_no_intake_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while digest is emitted");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after final beat");

endmodule

bind md5_hash_engine_core md5he_checker u_md5he_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);
`default_nettype wire

FILE: dv/md5_hash_engine_core_tb.sv
// Testbench for md5_hash_engine_core: random byte streams checked against an MD5 predictor.
`timescale 1ns / 100ps
module md5_hash_engine_core_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam logic [15:0][4:0] ROT_TBL = {
    5'd21, 5'd15, 5'd10, 5'd6,  5'd23, 5'd16, 5'd11, 5'd4,
    5'd20, 5'd14, 5'd9,  5'd5,  5'd22, 5'd17, 5'd12, 5'd7
  };

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last_word;
  } digest_beat_t;

  typedef enum int {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE,
    PH_HOLDOFF
  } phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        last_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_hash_engine_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .byte_valid_i (byte_valid),
    .last_i       (last_flag),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .digest_word_o(digest_word),
    .word_index_o (word_index),
    .last_word_o  (last_word)
  );

  // MD5 digest predictor state
  logic [31:0]  sine_k [64];
  logic [31:0]  chain_q [4];
  logic [7:0]   blk_bytes [64];
  int unsigned  blk_fill;
  logic [63:0]  msg_bits;

  msg_beat_t    send_q [$];
  digest_beat_t digest_q [$];
  phase_e       phase = PH_STEADY;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  n_err = 0;
  int unsigned  n_items;
  int unsigned  n_msgs;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_cnt = 0;
  logic         hold_done = 1'b0;
  digest_beat_t want;

  function automatic void digest_restart();
    chain_q[0] = md5he_pkg::IV_A;
    chain_q[1] = md5he_pkg::IV_B;
    chain_q[2] = md5he_pkg::IV_C;
    chain_q[3] = md5he_pkg::IV_D;
    blk_fill   = 0;
    msg_bits   = '0;
  endfunction

  function automatic void md5_fold_block();
    logic [31:0] a, b, c, d, f, m, t;
    int r, g, s;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      m = {blk_bytes[4*g+3], blk_bytes[4*g+2], blk_bytes[4*g+1], blk_bytes[4*g]};
      f = f + a + sine_k[r] + m;
      s = ROT_TBL[(r / 16) * 4 + (r % 4)];
      t = d;
      d = c;
      c = b;
      b = b + ((f << s) | (f >> (32 - s)));
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
  endfunction

  function automatic void md5_take(input msg_beat_t bt);
    digest_beat_t db;
    logic [31:0] w;
    int p, k;
    if (bt.byte_valid) begin
      blk_bytes[blk_fill] = bt.data;
      blk_fill = (blk_fill + 1) % 64;
      msg_bits = msg_bits + 64'd8;
      if (blk_fill == 0) md5_fold_block();
    end
    if (bt.last) begin
      p = blk_fill;
      blk_bytes[p] = md5he_pkg::PAD_MARK;
      for (k = p + 1; k < 64; k++) blk_bytes[k] = 8'h00;
      if (p >= 56) begin
        md5_fold_block();
        for (k = 0; k < 56; k++) blk_bytes[k] = 8'h00;
      end
      for (k = 0; k < 8; k++) blk_bytes[56+k] = msg_bits[8*k +: 8];
      md5_fold_block();
      for (k = 0; k < 4; k++) begin
        w = chain_q[k];
        db.word      = {w[7:0], w[15:8], w[23:16], w[31:24]};
        db.index     = 2'(k);
        db.last_word = (k == 3);
        digest_q.push_back(db);
      end
      digest_restart();
    end
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        {data_byte, byte_valid, last_flag} <= send_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (phase == PH_HOLDOFF && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) md5_take({data_byte, byte_valid, last_flag});
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat: expected none, actual word %h index %0d last %b",
                   $time, digest_word, word_index, last_word);
          n_err++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word);
            n_err++;
          end
          if (word_index !== want.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.index, word_index);
            n_err++;
          end
          if (last_word !== want.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time, want.last_word, last_word);
            n_err++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_beat(input logic [7:0] d, input logic bv, input logic lst);
    msg_beat_t bt;
    bt.data       = d;
    bt.byte_valid = bv;
    bt.last       = lst;
    send_q.push_back(bt);
    if (bv || lst) n_items++;
  endtask

  task automatic push_message(input int len);
    int i;
    bit tail_empty;
    tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, (i == len - 1) && !tail_empty);
    end
    if (tail_empty) push_beat(8'($urandom), 1'b0, 1'b1);
    n_msgs++;
  endtask

  function automatic int pick_length();
    int r;
    int edges [6] = '{55, 56, 57, 63, 64, 120};
    r = $urandom_range(0, 99);
    if (r < 8) return edges[$urandom_range(0, 5)];
    if (r < 10) return $urandom_range(65, 140);
    return $urandom_range(0, 12);
  endfunction

  task automatic push_random(input int unsigned budget);
    n_items = 0;
    n_msgs  = 0;
    while (n_items < budget || n_msgs < 2) begin
      if ($urandom_range(0, 7) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      push_message(pick_length());
    end
  endtask

  task automatic enter_phase(input phase_e p);
    phase = p;
    case (p)
      PH_SEND_IDLE: begin
        send_idle_pct  = 84;
        recv_stall_pct = 0;
      end
      PH_RECV_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 84;
      end
      PH_BOTH_IDLE: begin
        send_idle_pct  = 28;
        recv_stall_pct = 28;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || in_valid || digest_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    real sv;
    int i;
    for (i = 0; i < 64; i++) begin
      sv = $sin(i + 1.0);
      if (sv < 0.0) sv = -sv;
      sine_k[i] = 32'(longint'($floor(sv * 4294967296.0)));
    end
    digest_restart();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    enter_phase(PH_STEADY);
    n_items = 0;
    n_msgs  = 0;
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'h5a, 1'b0, 1'b0);
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'ha5, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hff, 1'b1, 1'b1);
    push_beat(md5he_pkg::PAD_MARK, 1'b1, 1'b1);
    push_message(56);
    push_message(64);
    wait_drained();

    enter_phase(PH_STEADY);
    push_random(10);
    wait_drained();
    enter_phase(PH_SEND_IDLE);
    push_random(10);
    wait_drained();
    enter_phase(PH_RECV_STALL);
    push_random(10);
    wait_drained();
    enter_phase(PH_BOTH_IDLE);
    push_random(10);
    wait_drained();
    enter_phase(PH_HOLDOFF);
    push_message(12);
    push_message(3);
    push_message(0);
    push_message(9);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (digest_q.size() != 0) begin
      $display("%0t: %0d digest beats expected, actual none", $time, digest_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
